### hdl/fpha_pkg.sv
// Shared constants, types and helpers for the flame point histogram accumulator.
`timescale 1ns / 1ps
package fpha_pkg;

    localparam int RASTER_WIDTH  = 1024;
    localparam int RASTER_HEIGHT = 1024;
    localparam int GROUP_SIZE    = 8;
    localparam int THREAD_COUNT  = 12;

    localparam int XW         = $clog2(RASTER_WIDTH);
    localparam int YW         = $clog2(RASTER_HEIGHT);
    localparam int CELL_W     = XW + YW;
    localparam int CELL_COUNT = RASTER_WIDTH * RASTER_HEIGHT;
    localparam int GIDX_W     = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int FILL_W     = $clog2(GROUP_SIZE + 1);
    localparam int TIDX_W     = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int FRAC_BITS  = 40;

    localparam logic [4:0] WARMUP_LIMIT = 5'd20;
    localparam logic [4:0] WARMUP_MAX   = 5'd21;

    localparam logic       OP_PLOT = 1'b0;
    localparam logic       OP_READ = 1'b1;
    localparam logic       KIND_GROUP = 1'b0;
    localparam logic       KIND_READ  = 1'b1;

    localparam logic [1:0] REG_X_OFFSET = 2'd0;
    localparam logic [1:0] REG_Y_OFFSET = 2'd1;
    localparam logic [1:0] REG_X_SCALE  = 2'd2;
    localparam logic [1:0] REG_Y_SCALE  = 2'd3;
    localparam logic [31:0] SCALE_RESET = 32'd33554432;

    localparam int RGB_W = 128;

    // Word handed from front to back.
    typedef struct packed {
        logic              is_read;
        logic              read_ok;    // read index inside raster
        logic              group_end;  // flush group after buffering this point
        logic              point_ok;   // point inside raster
        logic [CELL_W-1:0] cell_addr;
        logic [63:0]       color;
        logic              bad;
        logic [3:0]        thread;
    } work_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

endpackage

### hdl/fpha_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module fpha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/fpha_mapper.sv
// Front part: two-stage coordinate mapping of each accepted word.
`timescale 1ns / 1ps
module fpha_mapper import fpha_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         operation,
    input  logic [3:0]   thread,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic         point_bad,
    input  logic [63:0]  color,
    input  logic         group_last,
    input  logic [19:0]  cell_index,
    input  logic [31:0]  x_offset,
    input  logic [31:0]  y_offset,
    input  logic [31:0]  x_scale,
    input  logic [31:0]  y_scale,
    output logic         out_valid,
    input  logic         out_ready,
    output work_t        out_word
);
    // stage 1: offset sums and products registered
    logic        s1_valid_reg;
    logic        s1_op_reg, s1_last_reg, s1_bad_reg;
    logic [3:0]  s1_thread_reg;
    logic [63:0] s1_color_reg;
    logic [19:0] s1_index_reg;
    logic        s1_xneg_reg, s1_yneg_reg;
    logic [63:0] s1_xmag_reg, s1_ymag_reg;
    logic [FILL_W-1:0] fill_reg;

    logic        s2_valid_reg;
    work_t       s2_word_reg;

    logic signed [32:0] xsum, ysum;
    logic [32:0] xabs, yabs;
    logic        adv1, adv2;

    assign out_valid = s2_valid_reg;
    assign out_word  = s2_word_reg;
    assign adv2      = !s2_valid_reg || out_ready;
    assign adv1      = !s1_valid_reg || adv2;
    assign in_ready  = adv1;

    assign xsum = 33'(point_x) + 33'(signed'(x_offset));
    assign ysum = 33'(point_y) + 33'(signed'(y_offset));
    assign xabs = xsum[32] ? 33'(-xsum) : 33'(xsum);
    assign yabs = ysum[32] ? 33'(-ysum) : 33'(ysum);

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_op_reg     <= operation;
            s1_last_reg   <= group_last;
            s1_bad_reg    <= point_bad;
            s1_thread_reg <= thread;
            s1_color_reg  <= color;
            s1_index_reg  <= cell_index;
            s1_xneg_reg   <= xsum[32];
            s1_yneg_reg   <= ysum[32];
            s1_xmag_reg   <= 64'(xabs[31:0]) * 64'(x_scale) ;
            s1_ymag_reg   <= 64'(yabs[31:0]) * 64'(y_scale);
        end
    end

    // |sum| up to 2^32 needs bit 32; fold it in as an extra scale term
    logic x_top_reg, y_top_reg;
    logic [31:0] xs_reg, ys_reg;
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            x_top_reg <= xabs[32];
            y_top_reg <= yabs[32];
            xs_reg    <= x_scale;
            ys_reg    <= y_scale;
        end
    end

    function automatic logic [XW:0] map_c(input logic neg, input logic top,
        input logic [63:0] mag0, input logic [31:0] sc, input int size);
        logic [64:0] mag;
        logic [64:0] base;
        logic [64:0] v;
        logic        ok;
        mag  = {1'b0, mag0} + (top ? {1'b0, sc, 32'd0} : 65'd0);
        base = 65'(size / 2) << FRAC_BITS;
        if (!neg)
        begin
            v = 65'(size / 2) + (mag >> FRAC_BITS);
            ok = 1'b1;
        end
        else
        begin
            ok = (mag <= base);
            v  = (base - mag) >> FRAC_BITS;
        end
        ok = ok && (v < 65'(size));
        return {ok, v[XW-1:0]};
    endfunction

    logic [XW:0] xm;
    logic [YW:0] ym;
    assign xm = map_c(s1_xneg_reg, x_top_reg, s1_xmag_reg, xs_reg, RASTER_WIDTH);
    assign ym = (YW+1)'(map_c(s1_yneg_reg, y_top_reg, s1_ymag_reg, ys_reg, RASTER_HEIGHT));

    logic full_now;
    assign full_now = (fill_reg == FILL_W'(GROUP_SIZE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fill_reg     <= '0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
                if (s1_valid_reg && s1_op_reg == OP_PLOT)
                begin
                    fill_reg <= (s1_last_reg || full_now) ? '0 : fill_reg + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_word_reg.is_read   <= (s1_op_reg == OP_READ);
            s2_word_reg.read_ok   <= (32'(s1_index_reg) < 32'(CELL_COUNT));
            s2_word_reg.group_end <= s1_last_reg || full_now;
            s2_word_reg.point_ok  <= xm[XW] && ym[YW];
            s2_word_reg.cell_addr <= (s1_op_reg == OP_READ) ? CELL_W'(s1_index_reg)
                                     : {ym[YW-1:0], xm[XW-1:0]};
            s2_word_reg.color     <= s1_color_reg;
            s2_word_reg.bad       <= s1_bad_reg;
            s2_word_reg.thread    <= s1_thread_reg;
        end
    end
endmodule

### hdl/fpha_fifo.sv
// Short queue between the front and back parts.
`timescale 1ns / 1ps
module fpha_fifo import fpha_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  work_t wr_word,
    output logic  rd_valid,
    input  logic  rd_ready,
    output work_t rd_word
);
    localparam int DEPTH = 4;
    work_t       slot_reg [DEPTH];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;
    logic        do_wr, do_rd;

    assign wr_ready = (cnt_reg != 3'(DEPTH));
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_word  = slot_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr) wp_reg <= wp_reg + 2'd1;
            if (do_rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(do_wr) - 3'(do_rd);
        end
    end
endmodule

### hdl/fpha_engine.sv
// Back part: group buffer, warm-up, histogram read-modify-write and results.
`timescale 1ns / 1ps
module fpha_engine import fpha_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  work_t        in_word,
    output logic         res_valid,
    input  logic         res_pop,
    output logic         kind,
    output logic         group_reset,
    output logic [31:0]  cell_red,
    output logic [31:0]  cell_green,
    output logic [31:0]  cell_blue,
    output logic [31:0]  cell_density,
    output logic [31:0]  good_hits,
    output logic [31:0]  miss_hits,
    output logic [31:0]  bad_hits
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;   // read issued
    localparam logic [2:0] ST_RDOUT = 3'd2;   // read data valid
    localparam logic [2:0] ST_PADDR = 3'd3;   // plot: issue read
    localparam logic [2:0] ST_PWAIT = 3'd4;   // plot: data comes back
    localparam logic [2:0] ST_PWR   = 3'd5;   // plot: write back
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    // group buffer (flop rows; entries read only below fill)
    logic [CELL_W-1:0] pcell_reg  [GROUP_SIZE];
    logic              pok_reg    [GROUP_SIZE];
    logic [63:0]       pcolor_reg [GROUP_SIZE];
    logic [FILL_W-1:0] fill_reg;
    logic              pbad_reg;
    logic [GIDX_W-1:0] idx_reg;
    logic [4:0]        warm_reg [THREAD_COUNT];
    logic [31:0]       good_reg, miss_reg, bad_reg;

    // result holding register
    logic              rv_reg, rkind_reg, rreset_reg;
    logic [RGB_W-1:0]  rcell_reg;

    // a read of an index beyond the raster returns zeros
    logic              rok_reg;

    // clearing pass over the stores
    logic              clr_reg;
    logic [CELL_W-1:0] clr_addr_reg;

    logic              mem_we;
    logic [CELL_W-1:0] mem_addr, waddr;
    logic [RGB_W-1:0]  mem_wdata, mem_rdata;
    logic [CELL_W-1:0] raddr_reg;

    fpha_ram #(.WIDTH(RGB_W), .DEPTH(CELL_COUNT)) u_store (
        .clk  (clk),
        .we   (mem_we),
        .waddr(waddr),
        .wdata(mem_wdata),
        .raddr(mem_addr),
        .rdata(mem_rdata)
    );

    logic accept;
    assign in_ready  = !clr_reg && (state_reg == ST_IDLE) && !rv_reg;
    assign accept    = in_valid && in_ready;
    assign res_valid = rv_reg;

    assign kind         = rkind_reg;
    assign group_reset  = rreset_reg;
    assign cell_red     = rcell_reg[31:0];
    assign cell_green   = rcell_reg[63:32];
    assign cell_blue    = rcell_reg[95:64];
    assign cell_density = rcell_reg[127:96];
    assign good_hits    = good_reg;
    assign miss_hits    = miss_reg;
    assign bad_hits     = bad_reg;

    logic [63:0] cur_color;
    assign cur_color = pcolor_reg[idx_reg];

    always_comb
    begin
        mem_addr  = raddr_reg;
        mem_we    = 1'b0;
        waddr     = raddr_reg;
        mem_wdata = {sat_add(mem_rdata[127:96], cur_color[63:48]),
                     sat_add(mem_rdata[95:64],  cur_color[47:32]),
                     sat_add(mem_rdata[63:32],  cur_color[31:16]),
                     sat_add(mem_rdata[31:0],   cur_color[15:0])};
        if (clr_reg)
        begin
            mem_we    = 1'b1;
            waddr     = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_PWR)
        begin
            mem_we = 1'b1;
        end
        if (accept)
        begin
            mem_addr = in_word.cell_addr;
        end
        else if (state_reg == ST_PADDR)
        begin
            mem_addr = pcell_reg[idx_reg];
        end
    end

    // group end decision taken at accept time
    logic [4:0] w_cur;
    logic       t_ok, plot_go, bad_go;
    assign t_ok    = (in_word.thread < 4'(THREAD_COUNT));
    assign w_cur   = t_ok ? warm_reg[TIDX_W'(in_word.thread)] : 5'd0;
    assign plot_go = t_ok && (w_cur > WARMUP_LIMIT);
    assign bad_go  = plot_go && (pbad_reg || in_word.bad);

    logic last_idx;
    assign last_idx = (FILL_W'(idx_reg) + FILL_W'(1) == fill_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_word.is_read)
                    state_next = ST_RD;
                else if (accept && in_word.group_end)
                    state_next = (plot_go && !(pbad_reg || in_word.bad)) ? ST_PADDR : ST_DONE;
            end
            ST_RD:    state_next = ST_RDOUT;
            ST_RDOUT: state_next = ST_IDLE;
            ST_PADDR: state_next = ST_PWAIT;
            ST_PWAIT: state_next = pok_reg[idx_reg] ? ST_PWR : (last_idx ? ST_DONE : ST_PADDR);
            ST_PWR:   state_next = last_idx ? ST_DONE : ST_PADDR;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && !in_word.is_read)
        begin
            pcell_reg[GIDX_W'(fill_reg)]  <= in_word.cell_addr;
            pok_reg[GIDX_W'(fill_reg)]    <= in_word.point_ok;
            pcolor_reg[GIDX_W'(fill_reg)] <= in_word.color;
        end
        if (accept)
        begin
            raddr_reg <= in_word.cell_addr;
        end
        else if (state_reg == ST_PADDR)
        begin
            raddr_reg <= pcell_reg[idx_reg];
        end
        if (state_reg == ST_RDOUT)
        begin
            rcell_reg <= rok_reg ? mem_rdata : '0;
        end
        else if (state_reg == ST_DONE)
        begin
            rcell_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            pbad_reg     <= 1'b0;
            idx_reg      <= '0;
            good_reg     <= '0;
            miss_reg     <= '0;
            bad_reg      <= '0;
            rv_reg       <= 1'b0;
            rkind_reg    <= KIND_GROUP;
            rreset_reg   <= 1'b0;
            rok_reg      <= 1'b0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            for (int t = 0; t < THREAD_COUNT; t++)
            begin
                warm_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CELL_W'(1);
                if (clr_addr_reg == CELL_W'(CELL_COUNT - 1))
                    clr_reg <= 1'b0;
            end
            if (rv_reg && res_pop)
                rv_reg <= 1'b0;
            if (accept && in_word.is_read)
                rok_reg <= in_word.read_ok;
            if (accept && !in_word.is_read)
            begin
                if (in_word.group_end)
                begin
                    fill_reg   <= fill_reg + FILL_W'(1);
                    idx_reg    <= '0;
                    rreset_reg <= bad_go;
                    // a bad group on a warmed-up thread clears the thread's warm-up instead of counting it
                    if (t_ok)
                    begin
                        warm_reg[TIDX_W'(in_word.thread)] <= bad_go ? 5'd0 :
                            ((w_cur >= WARMUP_MAX) ? WARMUP_MAX : w_cur + 5'd1);
                    end
                    if (bad_go)
                    begin
                        bad_reg <= sat_inc(bad_reg);
                    end
                end
                else
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                    pbad_reg <= pbad_reg || in_word.bad;
                end
            end
            if (state_reg == ST_PWAIT)
            begin
                if (pok_reg[idx_reg])
                    good_reg <= sat_inc(good_reg);
                else
                    miss_reg <= sat_inc(miss_reg);
                if (!pok_reg[idx_reg] && !last_idx)
                    idx_reg <= idx_reg + GIDX_W'(1);
            end
            if (state_reg == ST_PWR && !last_idx)
                idx_reg <= idx_reg + GIDX_W'(1);
            if (state_reg == ST_RDOUT)
            begin
                rv_reg     <= 1'b1;
                rkind_reg  <= KIND_READ;
                rreset_reg <= 1'b0;
            end
            if (state_reg == ST_DONE)
            begin
                rv_reg    <= 1'b1;
                rkind_reg <= KIND_GROUP;
                fill_reg  <= '0;
                pbad_reg  <= 1'b0;
            end
        end
    end
endmodule

### hdl/flame_point_histogram_accumulator_top.sv
// Top level of the flame point histogram accumulator.
//  channel | handshake       | carries
//  input   | push / full     | operation, thread, point, colors, group_last, cell_index
//  result  | pop / empty     | kind, group_reset, cell colors, hit counters
//  config  | cfg_valid/ready | cfg_index, cfg_data
// Points enter the mapper at one a cycle unless it stalls, and wait in a 4-word queue.
// At the end of a warmed-up group with no bad point, each point inside the raster gets
// a read-modify-write of the store and each point outside only the read; a read passes
// through read-issued and read-data states; a finished group adds a done state for its
// result. After reset a clearing pass zeroes RASTER_WIDTH*RASTER_HEIGHT store cells.
// One result word is held; the back part stalls until it is popped.
`timescale 1ns / 1ps
module flame_point_histogram_accumulator_top import fpha_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        operation,
    input  logic [3:0]  thread,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic        point_bad,
    input  logic [15:0] color_red,
    input  logic [15:0] color_green,
    input  logic [15:0] color_blue,
    input  logic [15:0] color_density,
    input  logic        group_last,
    input  logic [19:0] cell_index,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic        group_reset,
    output logic [31:0] cell_red,
    output logic [31:0] cell_green,
    output logic [31:0] cell_blue,
    output logic [31:0] cell_density,
    output logic [31:0] good_hits,
    output logic [31:0] miss_hits,
    output logic [31:0] bad_hits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [31:0] x_off_reg, y_off_reg, x_sc_reg, y_sc_reg;
    logic        in_ready, m_valid, m_ready, f_valid, e_ready, res_valid;
    work_t       m_word, f_word;

    assign cfg_ready = 1'b1;
    assign full      = !in_ready;
    assign empty     = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg <= '0;
            y_off_reg <= '0;
            x_sc_reg  <= SCALE_RESET;
            y_sc_reg  <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_X_OFFSET: x_off_reg <= cfg_data;
                REG_Y_OFFSET: y_off_reg <= cfg_data;
                REG_X_SCALE:  x_sc_reg  <= cfg_data;
                REG_Y_SCALE:  y_sc_reg  <= cfg_data;
                default:      x_off_reg <= x_off_reg;
            endcase
        end
    end

    fpha_mapper u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (in_ready),
        .operation (operation),
        .thread    (thread),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_bad (point_bad),
        .color     ({color_density, color_blue, color_green, color_red}),
        .group_last(group_last),
        .cell_index(cell_index),
        .x_offset  (x_off_reg),
        .y_offset  (y_off_reg),
        .x_scale   (x_sc_reg),
        .y_scale   (y_sc_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_word)
    );

    fpha_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_valid(m_valid),
        .wr_ready(m_ready),
        .wr_word (m_word),
        .rd_valid(f_valid),
        .rd_ready(e_ready),
        .rd_word (f_word)
    );

    fpha_engine u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (f_valid),
        .in_ready    (e_ready),
        .in_word     (f_word),
        .res_valid   (res_valid),
        .res_pop     (pop),
        .kind        (kind),
        .group_reset (group_reset),
        .cell_red    (cell_red),
        .cell_green  (cell_green),
        .cell_blue   (cell_blue),
        .cell_density(cell_density),
        .good_hits   (good_hits),
        .miss_hits   (miss_hits),
        .bad_hits    (bad_hits)
    );
endmodule

### hdl/fpha_checker.sv
// Port-level checks for the accumulator, bound to the top level.
`timescale 1ns / 1ps
module fpha_checker import fpha_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        kind,
    input logic        group_reset,
    input logic [31:0] cell_red,
    input logic [31:0] good_hits,
    input logic [31:0] miss_hits,
    input logic [31:0] bad_hits
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(cell_red)))
        else $error("result word changed while waiting");
    a_reset_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_READ) |-> !group_reset)
        else $error("read result flagged reset");
    a_group_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_GROUP) |-> (cell_red == 32'd0))
        else $error("group result carries cell data");
    a_good_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (good_hits >= $past(good_hits) && miss_hits >= $past(miss_hits)
                  && bad_hits >= $past(bad_hits)))
        else $error("hit counter went down");
endmodule

bind flame_point_histogram_accumulator_top fpha_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .group_reset(group_reset),
    .cell_red   (cell_red),
    .good_hits  (good_hits),
    .miss_hits  (miss_hits),
    .bad_hits   (bad_hits)
);

### tb/tb_flame_point_histogram_accumulator_top.sv
// Self-checking testbench for the flame point histogram accumulator top level.
`timescale 1ns / 1ps
module tb_flame_point_histogram_accumulator_top;
    import fpha_pkg::*;

    localparam int WATCHDOG_LIMIT = 5_000_000;  // must outlast the clearing pass after reset
    localparam int SETTLE_CYCLES  = 80;

    typedef struct {
        logic        op;
        logic [3:0]  thr;
        logic [31:0] x;
        logic [31:0] y;
        logic        bad;
        logic [15:0] r, g, b, d;
        logic        last;
        logic [19:0] idx;
    } point_word_t;

    typedef struct {
        logic        kind;
        logic        rst;
        logic [31:0] r, g, b, d;
        logic [31:0] good, miss, badc;
    } result_word_t;

    typedef struct {
        bit          hit;
        int unsigned loc;
        logic [15:0] r, g, b, d;
    } pending_point_t;

    typedef struct {
        logic [31:0] r, g, b, d;
    } cell_sum_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        operation;
    logic [3:0]  thread;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        point_bad;
    logic [15:0] color_red, color_green, color_blue, color_density;
    logic        group_last;
    logic [19:0] cell_index;
    logic        empty;
    logic        pop;
    logic        kind;
    logic        group_reset;
    logic [31:0] cell_red, cell_green, cell_blue, cell_density;
    logic [31:0] good_hits, miss_hits, bad_hits;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    flame_point_histogram_accumulator_top i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .thread(thread), .point_x(point_x), .point_y(point_y),
        .point_bad(point_bad), .color_red(color_red), .color_green(color_green),
        .color_blue(color_blue), .color_density(color_density),
        .group_last(group_last), .cell_index(cell_index),
        .empty(empty), .pop(pop), .kind(kind), .group_reset(group_reset),
        .cell_red(cell_red), .cell_green(cell_green), .cell_blue(cell_blue),
        .cell_density(cell_density), .good_hits(good_hits), .miss_hits(miss_hits),
        .bad_hits(bad_hits), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0]    x_off, y_off, x_scl, y_scl;
    cell_sum_t      histogram [int unsigned];
    int unsigned    touched_cells [$];
    logic [4:0]     warmup [THREAD_COUNT];
    pending_point_t pending [$];
    bit             pending_bad;
    logic [31:0]    good_cnt, miss_cnt, bad_cnt;

    point_word_t  point_q [$];
    result_word_t expected_q [$];

    int  errors = 0;
    int  idle_cycles = 0;
    bit  in_fire = 0;
    bit  out_fire = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    int  rx_hold = 0;
    bit  tx_burst = 0;
    bit  rx_burst = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_one(logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

    // (p + off) * scale carries 40 fraction bits; centered on size/2
    function automatic bit map_axis(logic [31:0] p, logic [31:0] off, logic [31:0] scl,
                                    int size, output int unsigned pos);
        longint       s;
        logic [63:0]  a;
        logic [127:0] mag, base, v;
        s = longint'($signed(p)) + longint'($signed(off));
        a = (s >= 0) ? s : -s;
        mag = {64'd0, a} * {96'd0, scl};
        base = 128'(size / 2) << FRAC_BITS;
        pos = 0;
        if (s >= 0)
            v = 128'(size / 2) + (mag >> FRAC_BITS);
        else
        begin
            if (mag > base)
                return 0;
            v = (base - mag) >> FRAC_BITS;
        end
        if (v >= 128'(size))
            return 0;
        pos = v[31:0];
        return 1;
    endfunction

    function automatic void predict_word(point_word_t w);
        result_word_t   res;
        pending_point_t pp;
        cell_sum_t      cs;
        int unsigned    col, row;
        bit             in_x, in_y, plot;
        logic [4:0]     wc;
        res = '{default: '0};
        if (w.op == OP_READ)
        begin
            res.kind = KIND_READ;
            if (histogram.exists(32'(w.idx)))
            begin
                cs = histogram[32'(w.idx)];
                res.r = cs.r; res.g = cs.g; res.b = cs.b; res.d = cs.d;
            end
        end
        else
        begin
            in_x = map_axis(w.x, x_off, x_scl, RASTER_WIDTH, col);
            in_y = map_axis(w.y, y_off, y_scl, RASTER_HEIGHT, row);
            pp.hit = in_x && in_y;
            pp.loc = col + row * RASTER_WIDTH;
            pp.r = w.r; pp.g = w.g; pp.b = w.b; pp.d = w.d;
            pending.push_back(pp);
            if (w.bad)
                pending_bad = 1;
            if (!w.last && pending.size() < GROUP_SIZE)
                return;
            if (w.thr < THREAD_COUNT)
            begin
                wc = warmup[w.thr];
                plot = wc > WARMUP_LIMIT;
                warmup[w.thr] = (wc >= WARMUP_MAX) ? WARMUP_MAX : wc + 5'd1;
                if (plot && pending_bad)
                begin
                    bad_cnt = sat_one(bad_cnt);
                    warmup[w.thr] = '0;
                    res.rst = 1'b1;
                end
                else if (plot)
                begin
                    foreach (pending[i])
                    begin
                        if (pending[i].hit)
                        begin
                            if (!histogram.exists(pending[i].loc))
                            begin
                                histogram[pending[i].loc] = '{default: '0};
                                touched_cells.push_back(pending[i].loc);
                            end
                            cs = histogram[pending[i].loc];
                            cs.r = sat_sum(cs.r, pending[i].r);
                            cs.g = sat_sum(cs.g, pending[i].g);
                            cs.b = sat_sum(cs.b, pending[i].b);
                            cs.d = sat_sum(cs.d, pending[i].d);
                            histogram[pending[i].loc] = cs;
                            good_cnt = sat_one(good_cnt);
                        end
                        else
                            miss_cnt = sat_one(miss_cnt);
                    end
                end
            end
            pending.delete();
            pending_bad = 0;
            res.kind = KIND_GROUP;
        end
        res.good = good_cnt;
        res.miss = miss_cnt;
        res.badc = bad_cnt;
        expected_q.push_back(res);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // handshakes are sampled at the rising edge, before the block's own updates land
    always @(posedge clk)
    begin
        result_word_t e;
        in_fire = rst_n && push && !full;
        out_fire = rst_n && pop && !empty;
        if (in_fire)
            predict_word(point_q.pop_front());
        if (out_fire)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected: kind %0b", kind);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                check_field("kind", 32'(e.kind), 32'(kind));
                check_field("group_reset", 32'(e.rst), 32'(group_reset));
                check_field("cell_red", e.r, cell_red);
                check_field("cell_green", e.g, cell_green);
                check_field("cell_blue", e.b, cell_blue);
                check_field("cell_density", e.d, cell_density);
                check_field("good_hits", e.good, good_hits);
                check_field("miss_hits", e.miss, miss_hits);
                check_field("bad_hits", e.badc, bad_hits);
            end
        end
        if (in_fire || out_fire || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("flame_point_histogram_accumulator_top test failed");
            $finish;
        end
    end

    // sender: head of point_q stays on the ports until accepted
    always @(negedge clk)
    begin
        if (rst_n && !(push && !in_fire))
        begin
            if (tx_wait > 0)
            begin
                tx_wait--;
                push <= 1'b0;
            end
            else if (point_q.size() > 0)
            begin
                operation <= point_q[0].op;
                thread <= point_q[0].thr;
                point_x <= point_q[0].x;
                point_y <= point_q[0].y;
                point_bad <= point_q[0].bad;
                color_red <= point_q[0].r;
                color_green <= point_q[0].g;
                color_blue <= point_q[0].b;
                color_density <= point_q[0].d;
                group_last <= point_q[0].last;
                cell_index <= point_q[0].idx;
                push <= 1'b1;
                if ($urandom_range(0, 30) == 0)
                    tx_burst = !tx_burst;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 12);
            end
            else
                push <= 1'b0;
        end
    end

    // note: point_q head is popped at the accepting edge, so index 0 is always
    // the next word to offer.

    always @(negedge clk)
    begin
        if (rst_n && !(pop && !out_fire))
        begin
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 30) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 12);
            end
        end
    end

    function automatic point_word_t plain_point(logic [3:0] thr, logic last);
        point_word_t w;
        w.op = OP_PLOT;
        w.thr = thr;
        w.x = 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
        w.y = 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
        case ($urandom_range(0, 9))
            0, 1: begin w.x = $urandom(); w.y = $urandom(); end
            2:    begin w.x = {28'd0, 4'($urandom())} << 22; w.y = 32'h0040_0000; end
            default: ;
        endcase
        w.bad = 1'b0;
        w.r = 16'($urandom()); w.g = 16'($urandom());
        w.b = 16'($urandom()); w.d = 16'($urandom());
        if ($urandom_range(0, 7) == 0)
            w.r = 16'hFFFF;
        w.last = last;
        w.idx = 20'($urandom());
        return w;
    endfunction

    function automatic point_word_t read_word(logic [19:0] c);
        point_word_t w;
        w = plain_point(4'($urandom()), 1'($urandom()));
        w.op = OP_READ;
        w.bad = 1'($urandom());
        w.idx = c;
        return w;
    endfunction

    task automatic queue_random(int n_items);
        int          issued;
        int          len;
        int          bad_at;
        int          sel;
        logic [3:0]  thr;
        point_word_t w;
        issued = 0;
        while (issued < n_items)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                if (touched_cells.size() > 0 && $urandom_range(0, 2) != 0)
                    point_q.push_back(read_word(20'(
                        touched_cells[$urandom_range(0, touched_cells.size() - 1)])));
                else
                    point_q.push_back(read_word(20'($urandom())));
                issued++;
            end
            else if (sel < 18)
            begin
                w = plain_point(4'($urandom()), 1'($urandom()));
                w.bad = ($urandom_range(0, 3) == 0);
                point_q.push_back(w);
                issued++;
            end
            else
            begin
                // well-formed group; most land on a few threads so they warm up
                sel = $urandom_range(0, 9);
                thr = 4'((sel < 7) ? $urandom_range(0, 2) : (sel < 9) ? $urandom_range(3, 11)
                                                                     : $urandom_range(12, 15));
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, GROUP_SIZE)
                                                  : $urandom_range(1, 3);
                bad_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, len - 1) : -1;
                for (int i = 0; i < len; i++)
                begin
                    w = plain_point(thr, i == len - 1);
                    if (i == GROUP_SIZE - 1 && $urandom_range(0, 1) == 0)
                        w.last = 1'b0;
                    w.bad = (i == bad_at);
                    point_q.push_back(w);
                end
                issued += len;
            end
        end
    endtask

    task automatic settle();
        wait (point_q.size() == 0 && expected_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_X_OFFSET: x_off = val;
            REG_Y_OFFSET: y_off = val;
            REG_X_SCALE:  x_scl = val;
            default:      y_scl = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mapping(logic [31:0] xo, logic [31:0] yo, logic [31:0] xs,
                               logic [31:0] ys);
        write_reg(REG_X_OFFSET, xo);
        write_reg(REG_Y_OFFSET, yo);
        write_reg(REG_X_SCALE, xs);
        write_reg(REG_Y_SCALE, ys);
    endtask

    initial
    begin
        point_word_t w;
        x_off = '0; y_off = '0; x_scl = SCALE_RESET; y_scl = SCALE_RESET;
        foreach (warmup[i])
            warmup[i] = '0;
        pending_bad = 0;
        good_cnt = '0; miss_cnt = '0; bad_cnt = '0;
        rst_n = 1'b0;
        push = 1'b0; pop = 1'b0;
        operation = OP_PLOT; thread = '0; point_x = '0; point_y = '0; point_bad = 1'b0;
        color_red = '0; color_green = '0; color_blue = '0; color_density = '0;
        group_last = 1'b0; cell_index = '0;
        cfg_valid = 1'b0; cfg_index = REG_X_OFFSET; cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: read extremes, coordinate extremes, full group with no last mark,
        // out-of-range thread, bad point in warm-up, read in the middle of a group
        point_q.push_back(read_word(20'd0));
        point_q.push_back(read_word(20'hFFFFF));
        w = plain_point(4'd0, 1'b1);
        w.x = 32'h8000_0000; w.y = 32'h7FFF_FFFF;
        point_q.push_back(w);
        w = plain_point(4'd1, 1'b1);
        w.x = 32'h7FFF_FFFF; w.y = 32'h8000_0000;
        w.r = 16'hFFFF; w.g = 16'hFFFF; w.b = 16'hFFFF; w.d = 16'hFFFF;
        point_q.push_back(w);
        for (int i = 0; i < GROUP_SIZE; i++)
            point_q.push_back(plain_point(4'd2, 1'b0));
        w = plain_point(4'd15, 1'b1);
        w.bad = 1'b1;
        point_q.push_back(w);
        point_q.push_back(plain_point(4'd12, 1'b1));
        w = plain_point(4'd0, 1'b1);
        w.bad = 1'b1;
        point_q.push_back(w);
        point_q.push_back(plain_point(4'd3, 1'b0));
        point_q.push_back(read_word(20'h80200));
        point_q.push_back(plain_point(4'd3, 1'b1));
        settle();

        set_mapping(32'd0, 32'd0, SCALE_RESET, SCALE_RESET);
        queue_random(300);
        settle();

        // receiver holds off while the sender keeps offering words
        rx_hold = 400;
        queue_random(120);
        settle();

        set_mapping(32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000,
                    32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000,
                    $urandom_range(32'h0080_0000, 32'h0400_0000),
                    $urandom_range(32'h0080_0000, 32'h0400_0000));
        queue_random(450);
        settle();

        set_mapping(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
        queue_random(150);
        settle();

        set_mapping(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        queue_random(150);
        settle();

        set_mapping(32'd0, 32'd0, 32'd0, 32'd0);
        queue_random(100);
        settle();

        set_mapping($urandom(), $urandom(), $urandom(), $urandom());
        queue_random(80);
        settle();

        set_mapping(32'd0, 32'd0, SCALE_RESET, SCALE_RESET);
        queue_random(450);
        settle();

        if (errors == 0)
            $display("flame_point_histogram_accumulator_top test passed");
        else
            $display("flame_point_histogram_accumulator_top test failed");
        $finish;
    end

endmodule
